/* rtl/core/spectrum_amplitude_phase_assert.svh */
// Assertion macros shared by the spectrum amplitude/phase RTL.
`ifndef SPECTRUM_AMPLITUDE_PHASE_ASSERT_SVH
`define SPECTRUM_AMPLITUDE_PHASE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SAP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/sap_pkg.sv */
// Shared constants, types and the arctangent table for the amplitude/phase pipeline.
`timescale 1ns / 1ps

package sap_pkg;

    // Field widths
    localparam int SAMPLE_WIDTH = 24;
    localparam int PHASE_WIDTH  = 16;
    localparam int AMP_W        = 25;
    localparam logic [AMP_W-1:0] AMP_MAX = '1;

    // Stream bus widths, padded to whole bytes
    localparam int S_TDATA_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W = ((AMP_W + PHASE_WIDTH + 7) / 8) * 8;

    // CORDIC datapath
    localparam int CORDIC_STEPS   = 32;
    localparam int ATAN_IDX_W     = $clog2(CORDIC_STEPS);
    localparam int PRESCALE_SHIFT = 28;
    localparam int ANGLE_W        = 32;
    localparam int X_W            = SAMPLE_WIDTH + PRESCALE_SHIFT + 3;
    localparam logic [ANGLE_W-1:0] ANGLE_PI    = ANGLE_W'(1) << (ANGLE_W - 1);
    localparam logic [ANGLE_W-1:0] ROUND_HALF  = ANGLE_W'(1) << (ANGLE_W - 1 - PHASE_WIDTH);

    // Square root datapath: one root bit per cell
    localparam int ROOT_W = SAMPLE_WIDTH + 1;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 3;
    localparam int SAT_W  = (ROOT_W > AMP_W) ? ROOT_W : AMP_W;

    // Chain length covers both the CORDIC and the root recurrences
    localparam int CHAIN_LEN = (CORDIC_STEPS > ROOT_W) ? CORDIC_STEPS : ROOT_W;
    localparam int IDX_W     = $clog2(CHAIN_LEN);

    // Arctangent of 2^-i in units of pi/2^31
    localparam logic [ANGLE_W-1:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    // One square-root recurrence: radicand bits still to consume, remainder, root so far
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sap_lane_t;

    // Everything one item carries along the chain
    typedef struct packed {
        logic                    zero;
        logic signed [X_W-1:0]   x;
        logic signed [X_W-1:0]   y;
        logic [ANGLE_W-1:0]      z;
        sap_lane_t               lane_a;
        sap_lane_t               lane_b;
    } sap_cell_t;

    function automatic logic [ANGLE_W-1:0] atan_lookup(input logic [IDX_W-1:0] idx);
        logic [ANGLE_W-1:0] angle;
        angle = '0;
        if (int'(idx) < CORDIC_STEPS) begin
            angle = ATAN_TAB[idx[ATAN_IDX_W-1:0]];
        end
        return angle;
    endfunction

endpackage

/* rtl/core/sap_front.sv */
// Input stage: neighbor state, magnitudes, squares and chain seeding.
`timescale 1ns / 1ps

module sap_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [sap_pkg::SAMPLE_WIDTH-1:0] real_part,
    input  logic signed [sap_pkg::SAMPLE_WIDTH-1:0] imag_part,
    input  logic                                first_bin,
    output logic                                out_valid,
    output sap_pkg::sap_cell_t                  out_data
);

    import sap_pkg::*;

    localparam int SQ_W = 2 * SAMPLE_WIDTH;

    logic                           accept;
    logic signed [SAMPLE_WIDTH-1:0] prev_real_reg, prev_imag_reg;
    logic signed [SAMPLE_WIDTH-1:0] base_real, base_imag;
    logic signed [SAMPLE_WIDTH:0]   diff_real, diff_imag;
    logic [SAMPLE_WIDTH-1:0]        abs_real, abs_imag, abs_dreal, abs_dimag;
    logic [SAMPLE_WIDTH:0]          neg_dreal, neg_dimag;

    logic                           v1_reg, v2_reg, v3_reg;
    logic signed [SAMPLE_WIDTH-1:0] re1_reg, im1_reg, re2_reg, im2_reg;
    logic [SAMPLE_WIDTH-1:0]        ar1_reg, ai1_reg, dr1_reg, di1_reg;
    logic [SQ_W-1:0]                sq_ar2_reg, sq_ai2_reg, sq_dr2_reg, sq_di2_reg;

    logic [SQ_W:0]                  mag_sum, diff_sum;
    logic signed [X_W-1:0]          x_ext, y_ext, x_sc, y_sc;
    sap_cell_t                      seed_next, seed_reg;

    assign accept = en && in_valid;

    // Previous bin, zero at a spectrum start
    assign base_real = first_bin ? '0 : prev_real_reg;
    assign base_imag = first_bin ? '0 : prev_imag_reg;
    assign diff_real = (SAMPLE_WIDTH+1)'(real_part) - (SAMPLE_WIDTH+1)'(base_real);
    assign diff_imag = (SAMPLE_WIDTH+1)'(imag_part) - (SAMPLE_WIDTH+1)'(base_imag);
    assign neg_dreal = -diff_real;
    assign neg_dimag = -diff_imag;

    // Magnitudes; the most negative sample still fits unsigned
    assign abs_real  = real_part[SAMPLE_WIDTH-1] ? (SAMPLE_WIDTH'(0) - real_part) : real_part;
    assign abs_imag  = imag_part[SAMPLE_WIDTH-1] ? (SAMPLE_WIDTH'(0) - imag_part) : imag_part;
    assign abs_dreal = diff_real[SAMPLE_WIDTH] ? neg_dreal[SAMPLE_WIDTH-1:0]
                                               : diff_real[SAMPLE_WIDTH-1:0];
    assign abs_dimag = diff_imag[SAMPLE_WIDTH] ? neg_dimag[SAMPLE_WIDTH-1:0]
                                               : diff_imag[SAMPLE_WIDTH-1:0];

    // Neighbor state updates on every accepted bin
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_real_reg <= '0;
            prev_imag_reg <= '0;
        end else if (accept) begin
            prev_real_reg <= real_part;
            prev_imag_reg <= imag_part;
        end
    end

    // Valid flags of the three front stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Stage 1 and 2 payload: magnitudes, then squares
    always_ff @(posedge aclk) begin
        if (en) begin
            re1_reg    <= real_part;
            im1_reg    <= imag_part;
            ar1_reg    <= abs_real;
            ai1_reg    <= abs_imag;
            dr1_reg    <= abs_dreal;
            di1_reg    <= abs_dimag;
            re2_reg    <= re1_reg;
            im2_reg    <= im1_reg;
            sq_ar2_reg <= ar1_reg * ar1_reg;
            sq_ai2_reg <= ai1_reg * ai1_reg;
            sq_dr2_reg <= dr1_reg * dr1_reg;
            sq_di2_reg <= di1_reg * di1_reg;
        end
    end

    // Stage 3: radicands and CORDIC start vector
    assign mag_sum  = {1'b0, sq_ar2_reg} + {1'b0, sq_ai2_reg};
    assign diff_sum = {1'b0, sq_dr2_reg} + {1'b0, sq_di2_reg};
    assign x_ext    = X_W'(re2_reg);
    assign y_ext    = X_W'(im2_reg);
    assign x_sc     = x_ext <<< PRESCALE_SHIFT;
    assign y_sc     = y_ext <<< PRESCALE_SHIFT;

    always_comb begin
        seed_next             = '0;
        seed_next.zero        = (re2_reg == '0) && (im2_reg == '0);
        seed_next.lane_a.rad  = RAD_W'(mag_sum);
        seed_next.lane_b.rad  = RAD_W'(diff_sum >> 1);
        // Left half-plane: turn by pi first
        if (re2_reg[SAMPLE_WIDTH-1]) begin
            seed_next.x = -x_sc;
            seed_next.y = -y_sc;
            seed_next.z = ANGLE_PI;
        end else begin
            seed_next.x = x_sc;
            seed_next.y = y_sc;
            seed_next.z = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            seed_reg <= seed_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = seed_reg;

endmodule

/* rtl/core/sap_cell.sv */
// One chain cell: a CORDIC vectoring step and a root bit for both radicands.
`timescale 1ns / 1ps
`include "spectrum_amplitude_phase_assert.svh"

module sap_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic [sap_pkg::IDX_W-1:0]    stage_idx,
    input  logic                         in_valid,
    input  sap_pkg::sap_cell_t           in_data,
    output logic                         out_valid,
    output sap_pkg::sap_cell_t           out_data
);

    import sap_pkg::*;

    logic signed [X_W-1:0] x_in, y_in, x_sh, y_sh;
    logic [ANGLE_W-1:0]    angle;
    sap_cell_t             data_next, data_reg;
    logic                  valid_reg;

    // Restoring square root: bring down two radicand bits, try root*4+1
    function automatic sap_lane_t sqrt_step(input sap_lane_t l);
        sap_lane_t          r;
        logic [REM_W-1:0]   trial_rem;
        logic [REM_W-1:0]   trial_sub;
        logic               fits;
        trial_rem = {l.rem[REM_W-3:0], l.rad[RAD_W-1 -: 2]};
        trial_sub = REM_W'({l.root, 2'b01});
        fits      = trial_rem >= trial_sub;
        r.rad     = l.rad << 2;
        r.rem     = fits ? (trial_rem - trial_sub) : trial_rem;
        r.root    = {l.root[ROOT_W-2:0], fits};
        return r;
    endfunction

    assign x_in  = in_data.x;
    assign y_in  = in_data.y;
    assign x_sh  = x_in >>> stage_idx;
    assign y_sh  = y_in >>> stage_idx;
    assign angle = atan_lookup(stage_idx);

    // Step logic; cells past the end of a recurrence pass its values on
    always_comb begin
        data_next = in_data;
        if (int'(stage_idx) < CORDIC_STEPS) begin
            if (!y_in[X_W-1]) begin
                data_next.x = x_in + y_sh;
                data_next.y = y_in - x_sh;
                data_next.z = in_data.z + angle;
            end else begin
                data_next.x = x_in - y_sh;
                data_next.y = y_in + x_sh;
                data_next.z = in_data.z - angle;
            end
        end
        if (int'(stage_idx) < ROOT_W) begin
            data_next.lane_a = sqrt_step(in_data.lane_a);
            data_next.lane_b = sqrt_step(in_data.lane_b);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Root remainder never exceeds twice the partial root
    `SAP_ASSERT_IMPL(a_rem_a_bound, aclk, aresetn, out_valid,
        out_data.lane_a.rem <= (REM_W'(out_data.lane_a.root) << 1), "lane a remainder too large")
    `SAP_ASSERT_IMPL(a_rem_b_bound, aclk, aresetn, out_valid,
        out_data.lane_b.rem <= (REM_W'(out_data.lane_b.root) << 1), "lane b remainder too large")
    // Requests move one cell per enabled cycle and freeze otherwise
    `SAP_ASSERT_NEXT(a_valid_moves, aclk, aresetn, en,
        out_valid == $past(in_valid), "cell valid did not follow its input")
    `SAP_ASSERT_NEXT(a_valid_holds, aclk, aresetn, !en,
        $stable(out_valid), "cell valid changed while stalled")

endmodule

/* rtl/core/spectrum_amplitude_phase.sv */
// Top level: complex bin to amplitude and phase, with optional interbin amplitude.
`timescale 1ns / 1ps

// Takes one complex spectrum bin per request and returns its amplitude and
// phase (2^(PHASE_WIDTH-1) = pi). A new bin is accepted on every clock in
// which the result side is not stalled, so the sustained rate is one bin
// per cycle. The path runs through three front stages (magnitudes, squares,
// seeding), one chain cell per step of the longer of the CORDIC and root
// recurrences, and the output register. The whole pipeline
// advances together and holds while a result waits in the output register
// with m_tready low. No bins are taken during reset. Set first_bin (tuser)
// on the first bin of each spectrum; interbin_mode should be changed only
// while no bins are in flight.
module spectrum_amplitude_phase (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration: interbin_mode
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    // Input bins
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [sap_pkg::S_TDATA_W-1:0] s_tdata,  // real_part, imag_part
    input  logic                          s_tuser,  // first_bin
    // Results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [sap_pkg::M_TDATA_W-1:0] m_tdata   // amplitude, phase
);

    import sap_pkg::*;

    logic                           interbin_mode_reg;
    logic                           en;
    logic signed [SAMPLE_WIDTH-1:0] real_part, imag_part;

    logic                           chain_valid [0:CHAIN_LEN];
    sap_cell_t                      chain_data  [0:CHAIN_LEN];

    sap_cell_t                      last;
    logic [ROOT_W-1:0]              amp_root;
    logic [SAT_W-1:0]               amp_ext;
    logic [AMP_W-1:0]               amplitude;
    logic [ANGLE_W-1:0]             z_rnd;
    logic [PHASE_WIDTH-1:0]         phase;

    logic                           m_tvalid_reg;
    logic [M_TDATA_W-1:0]           m_tdata_reg, m_tdata_next;

    // Mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interbin_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            interbin_mode_reg <= cfg_wdata;
        end
    end

    // Pipeline moves whenever the output register is free or being drained
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en && aresetn;

    assign real_part = s_tdata[SAMPLE_WIDTH-1:0];
    assign imag_part = s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];

    sap_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .real_part (real_part),
        .imag_part (imag_part),
        .first_bin (s_tuser),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0])
    );

    // Row of cells, one step each
    for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_cell
        sap_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .stage_idx (IDX_W'(i)),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    // Amplitude select and saturation
    assign last     = chain_data[CHAIN_LEN];
    assign amp_root = (interbin_mode_reg && (last.lane_b.root > last.lane_a.root))
                      ? last.lane_b.root : last.lane_a.root;
    assign amp_ext  = SAT_W'(amp_root);
    assign amplitude = (amp_ext > SAT_W'(AMP_MAX)) ? AMP_MAX : amp_ext[AMP_W-1:0];

    // Phase: round to nearest at output width, zero bin gives zero
    assign z_rnd = last.z + ROUND_HALF;
    assign phase = last.zero ? '0 : z_rnd[ANGLE_W-1 -: PHASE_WIDTH];

    assign m_tdata_next = M_TDATA_W'({phase, amplitude});

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= chain_valid[CHAIN_LEN];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
